/* hdl/cfd_pkg.sv */
package cfd_pkg;

  localparam int CHANNELS = 10;
  localparam int CH_W = 4;
  localparam int SUB_W = 3;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [SUB_W-1:0] SUB_CRC_FIRST = SUB_W'(2);
  localparam logic [SUB_W-1:0] SUB_CRC_LAST = SUB_W'(5);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [31:0] value;
    logic        word_ok;
    logic        last;
    logic        frame_ok;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [31:0]     word;
    logic            word_ok;
    logic            last;
    logic            frame_ok;
  } commit_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/crc_checked_float_frame_deframer.sv */
// measurement frame deframer with crc-8 checked words
// input channel: in_valid / in_ready / in_item, one frame byte per item;
//   frame_start marks byte 0 and drops any partial value
// output channel: out_valid / out_ready / out_item, one item per six bytes
//   with the channel index, stored value, word_ok, last and frame_ok
// throughput: one byte per cycle, no bubbles while the output drains
// the item for the sixth byte is written into the queue as that byte is taken;
//   the output register loads it when the queue pops, and out_valid rises with it
// the front tracks position, crc and word and pushes one entry per value
//   into a two-entry queue; the back updates the channel value store and
//   loads the output register
// when the receiver stalls the queue fills; in_ready falls only once both
//   queue entries and the output register hold items
// reset: position and crc restart, all stored channel values read zero,
//   queue and output are empty; ready is high the cycle after reset
module crc_checked_float_frame_deframer import cfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic    push;
  commit_t push_data;
  logic    full;
  logic    pop;
  logic    not_empty;
  commit_t pop_data;

  cfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  cfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  cfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* hdl/cfd_front.sv */
module cfd_front import cfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     queue_full,
  output logic     push,
  output commit_t  push_data
);

  logic [SUB_W-1:0] sub;
  logic [CH_W-1:0]  ch;
  logic [7:0]       crc;
  logic [31:0]      word;
  logic             word_error;
  logic             frame_error;

  logic [SUB_W-1:0] sub_cur;
  logic [CH_W-1:0]  ch_cur;
  logic [7:0]       crc_cur;
  logic [31:0]      word_cur;
  logic             we_cur;
  logic             fe_cur;
  logic             is_crc;
  logic             done;
  logic             accept;
  logic [7:0]       crc_next;
  logic [31:0]      word_next;
  logic             we_next;
  logic             ok;
  logic             is_last;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    sub_cur   = in_item.frame_start ? '0 : sub;
    ch_cur    = in_item.frame_start ? '0 : ch;
    crc_cur   = in_item.frame_start ? CRC_INIT : crc;
    word_cur  = in_item.frame_start ? '0 : word;
    we_cur    = in_item.frame_start ? 1'b0 : word_error;
    fe_cur    = in_item.frame_start ? 1'b0 : frame_error;
    is_crc    = (sub_cur == SUB_CRC_FIRST) || (sub_cur == SUB_CRC_LAST);
    done      = (sub_cur == SUB_CRC_LAST);
    crc_next  = is_crc ? CRC_INIT : crc_update(crc_cur, in_item.rx_byte);
    word_next = is_crc ? word_cur : {word_cur[23:0], in_item.rx_byte};
    we_next   = we_cur || (is_crc && (in_item.rx_byte != crc_cur));
    ok        = !we_next;
    is_last   = (ch_cur == CH_LAST);
    push_data.channel  = ch_cur;
    push_data.word     = word_next;
    push_data.word_ok  = ok;
    push_data.last     = is_last;
    push_data.frame_ok = is_last && !fe_cur && ok;
  end

  assign push = accept && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub         <= '0;
      ch          <= '0;
      crc         <= CRC_INIT;
      word        <= '0;
      word_error  <= 1'b0;
      frame_error <= 1'b0;
    end else if (accept) begin
      crc <= crc_next;
      if (done) begin
        sub        <= '0;
        word       <= '0;
        word_error <= 1'b0;
        if (is_last) begin
          ch          <= '0;
          frame_error <= 1'b0;
        end else begin
          ch          <= ch_cur + CH_W'(1);
          frame_error <= fe_cur || !ok;
        end
      end else begin
        sub         <= sub_cur + SUB_W'(1);
        ch          <= ch_cur;
        word        <= word_next;
        word_error  <= we_next;
        frame_error <= fe_cur;
      end
    end
  end

endmodule

/* hdl/cfd_queue.sv */
module cfd_queue import cfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  commit_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output commit_t pop_data
);

  commit_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/cfd_back.sv */
module cfd_back import cfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      not_empty,
  input  commit_t   pop_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [31:0] channel_values [CHANNELS];
  logic [31:0] value_next;

  assign pop = not_empty && (!out_valid || out_ready);
  assign value_next = pop_data.word_ok ? pop_data.word : channel_values[pop_data.channel];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        channel_values[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (pop_data.word_ok) begin
          channel_values[pop_data.channel] <= pop_data.word;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.channel  <= 4'(pop_data.channel);
      out_item.value    <= value_next;
      out_item.word_ok  <= pop_data.word_ok;
      out_item.last     <= pop_data.last;
      out_item.frame_ok <= pop_data.frame_ok;
    end
  end

endmodule
